/* hw/rtl/dark_frame_mean_std_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef DARK_FRAME_MEAN_STD_MACROS_SVH
`define DARK_FRAME_MEAN_STD_MACROS_SVH

`ifndef NO_ASSERTIONS
`define DFMS_ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("dfms: forbidden condition seen");
`define DFMS_ASSERT_IMPLIES(name, clk, rst, cond, conseq) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("dfms: implication violated");
`else
`define DFMS_ASSERT_NEVER(name, clk, rst, expr)
`define DFMS_ASSERT_IMPLIES(name, clk, rst, cond, conseq)
`endif

`endif

/* hw/rtl/dfms_pkg.sv */
package dfms_pkg;

   localparam int PIX_W       = 16;
   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 16;
   localparam int FRAME_W     = 10;
   localparam int N_W         = 11;
   localparam int SPROD_W     = SAMPLE_W + GAIN_W;
   localparam int FRAC_SHIFT  = 6;
   localparam int VAL_W       = 26;
   localparam int DIFF_W      = VAL_W + 1;
   localparam int SUM_W       = 64;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int ROOT_W      = SUM_W / 2;
   localparam int SQ_REM_W    = ROOT_W + 2;
   localparam int ENTRY_W     = VAL_W + SUM_W + 1;
   localparam int UPD_STAGES  = (VAL_W + 1) / 2;
   localparam int RES_STAGES  = (SUM_W + 1) / 2;
   localparam int SQRT_STAGES = ROOT_W;

   localparam logic [VAL_W-1:0] VAL_MAX = '1;
   localparam logic [1:0]       FIFO_FULL = 2'd2;

   typedef struct packed {
      logic               valid;
      logic [PIX_W-1:0]   pixel;
      logic [N_W-1:0]     n;
      logic [VAL_W-1:0]   mean;
      logic [SUM_W-1:0]   sum;
      logic               sat;
   } upd_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel;
      logic [VAL_W-1:0]   mean;
      logic [VAL_W-1:0]   std;
      logic               sat;
   } rsp_type;

   // One restoring division step: returns {quotient bit, new remainder}.
   function automatic logic [N_W:0] div_bit(input logic [N_W-1:0] rem, input logic b,
                                            input logic [N_W-1:0] n);
      logic [N_W:0] t;
      logic [N_W:0] diff;
      t    = {rem, b};
      diff = t - {1'b0, n};
      if (t >= {1'b0, n}) begin
         return {1'b1, diff[N_W-1:0]};
      end else begin
         return {1'b0, t[N_W-1:0]};
      end
   endfunction

endpackage

/* hw/rtl/dfms_ram.sv */
module dfms_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 91
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/dfms_update.sv */
`include "dark_frame_mean_std_macros.svh"

module dfms_update (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_accept,
   input  logic [dfms_pkg::SAMPLE_W-1:0]   in_sample,
   input  logic [dfms_pkg::GAIN_W-1:0]     in_gain,
   input  logic [dfms_pkg::PIX_W-1:0]      in_pixel,
   input  logic [dfms_pkg::FRAME_W-1:0]    in_frame,
   input  logic                            in_last,
   output logic                            hazard,
   output dfms_pkg::upd_type               upd
);

   localparam int VW = dfms_pkg::VAL_W;
   localparam int SW = dfms_pkg::SUM_W;
   localparam int NS = dfms_pkg::UPD_STAGES;

   typedef struct packed {
      logic                       valid;
      logic                       first;
      logic                       last;
      logic [dfms_pkg::PIX_W-1:0] pixel;
      logic [dfms_pkg::N_W-1:0]   n;
   } tag_type;

   typedef struct packed {
      tag_type                    tag;
      logic [VW-1:0]              p;
      logic [VW-1:0]              old_mean;
      logic [SW-1:0]              old_sum;
      logic                       old_sat;
      logic                       neg;
      logic [VW-1:0]              dvd;
      logic [dfms_pkg::N_W-1:0]   rem;
      logic [VW-1:0]              quo;
   } dv_type;

   typedef struct packed {
      tag_type                       tag;
      logic [VW-1:0]                 mean;
      logic [dfms_pkg::DIFF_W-1:0]   d;
      logic [dfms_pkg::DIFF_W-1:0]   e;
      logic [SW-1:0]                 old_sum;
      logic                          old_sat;
   } m_type;

   typedef struct packed {
      tag_type                       tag;
      logic [VW-1:0]                 mean;
      logic [dfms_pkg::PROD_W-1:0]   prod;
      logic [SW-1:0]                 old_sum;
      logic                          old_sat;
   } p_type;

   function automatic dv_type dv_step2(input dv_type x);
      dv_type                  y;
      logic [dfms_pkg::N_W:0]  r;
      y = x;
      for (int j = 0; j < 2; j++) begin
         r     = dfms_pkg::div_bit(y.rem, y.dvd[VW-1], y.tag.n);
         y.rem = r[dfms_pkg::N_W-1:0];
         y.quo = {y.quo[VW-2:0], r[dfms_pkg::N_W]};
         y.dvd = {y.dvd[VW-2:0], 1'b0};
      end
      return y;
   endfunction

   tag_type                          a_tag_ff, a_tag_in;
   logic [dfms_pkg::SPROD_W-1:0]     a_prod_ff, a_prod_in;
   dv_type                           dv_ff [NS];
   dv_type                           dv_in [NS];
   dv_type                           dv_a;
   m_type                            m_ff, m_in;
   p_type                            p_ff, p_in;
   dfms_pkg::upd_type                upd_ff, upd_in;

   logic [dfms_pkg::PIX_W-1:0]       rd_addr;
   logic [dfms_pkg::ENTRY_W-1:0]     rd_entry;
   logic                             wr_en;
   logic [dfms_pkg::ENTRY_W-1:0]     wr_data;

   logic [VW-1:0]                    p_a, old_a;
   logic [dfms_pkg::DIFF_W-1:0]      diff_a, ndiff_a;
   logic [VW:0]                      msum;
   logic [dfms_pkg::SUM_W:0]         add_sum;
   logic [SW-1:0]                    new_sum;
   logic                             new_sat;
   logic signed [dfms_pkg::DIFF_W-1:0] mul_a, mul_b;
   logic                             match;

   assign rd_addr = adv ? in_pixel : a_tag_ff.pixel;

   dfms_ram #(.ADDR_W(dfms_pkg::PIX_W), .DATA_W(dfms_pkg::ENTRY_W)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (p_ff.tag.pixel),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   always_comb begin
      a_tag_in.valid = in_accept;
      a_tag_in.first = (in_frame == '0);
      a_tag_in.last  = in_last;
      a_tag_in.pixel = in_pixel;
      a_tag_in.n     = dfms_pkg::N_W'(in_frame) + dfms_pkg::N_W'(1);
      a_prod_in      = dfms_pkg::SPROD_W'(in_sample) * dfms_pkg::SPROD_W'(in_gain);
   end

   // Entry read returns during stage A; split the difference into sign and magnitude.
   always_comb begin
      p_a     = a_prod_ff[VW+dfms_pkg::FRAC_SHIFT-1:dfms_pkg::FRAC_SHIFT];
      old_a   = rd_entry[VW-1:0];
      diff_a  = {1'b0, p_a} - {1'b0, old_a};
      ndiff_a = ~diff_a + dfms_pkg::DIFF_W'(1);
      dv_a.tag      = a_tag_ff;
      dv_a.p        = p_a;
      dv_a.old_mean = old_a;
      dv_a.old_sum  = rd_entry[VW+SW-1:VW];
      dv_a.old_sat  = rd_entry[dfms_pkg::ENTRY_W-1];
      dv_a.neg      = diff_a[dfms_pkg::DIFF_W-1];
      dv_a.dvd      = diff_a[dfms_pkg::DIFF_W-1] ? ndiff_a[VW-1:0] : diff_a[VW-1:0];
      dv_a.rem      = '0;
      dv_a.quo      = '0;
   end

   always_comb begin
      dv_in[0] = dv_step2(dv_a);
      for (int i = 1; i < NS; i++) begin
         dv_in[i] = dv_step2(dv_ff[i-1]);
      end
   end

   // Quotient truncates toward zero: apply the sign to the magnitude.
   always_comb begin
      msum = dv_ff[NS-1].neg ? ({1'b0, dv_ff[NS-1].old_mean} - {1'b0, dv_ff[NS-1].quo})
                             : ({1'b0, dv_ff[NS-1].old_mean} + {1'b0, dv_ff[NS-1].quo});
      m_in.tag     = dv_ff[NS-1].tag;
      m_in.mean    = dv_ff[NS-1].tag.first ? dv_ff[NS-1].p : msum[VW-1:0];
      m_in.d       = {1'b0, dv_ff[NS-1].p} - {1'b0, dv_ff[NS-1].old_mean};
      m_in.e       = {1'b0, dv_ff[NS-1].p} - {1'b0, m_in.mean};
      m_in.old_sum = dv_ff[NS-1].old_sum;
      m_in.old_sat = dv_ff[NS-1].old_sat;
   end

   always_comb begin
      mul_a        = $signed(m_ff.d);
      mul_b        = $signed(m_ff.e);
      p_in.tag     = m_ff.tag;
      p_in.mean    = m_ff.mean;
      p_in.prod    = dfms_pkg::PROD_W'(mul_a * mul_b);
      p_in.old_sum = m_ff.old_sum;
      p_in.old_sat = m_ff.old_sat;
   end

   // Accumulate positive increments only; saturate the sum and set the sticky flag. Frame 0 clears both.
   always_comb begin
      add_sum = {1'b0, p_ff.old_sum} +
                (dfms_pkg::SUM_W + 1)'(p_ff.prod[dfms_pkg::PROD_W-2:0]);
      new_sum = p_ff.old_sum;
      new_sat = p_ff.old_sat;
      if (p_ff.tag.first) begin
         new_sum = '0;
         new_sat = 1'b0;
      end else if (!p_ff.prod[dfms_pkg::PROD_W-1] && p_ff.prod != '0) begin
         if (add_sum[dfms_pkg::SUM_W]) begin
            new_sum = '1;
            new_sat = 1'b1;
         end else begin
            new_sum = add_sum[SW-1:0];
         end
      end
      wr_en   = adv && p_ff.tag.valid;
      wr_data = {new_sat, new_sum, p_ff.mean};
      upd_in.valid = p_ff.tag.valid && p_ff.tag.last;
      upd_in.pixel = p_ff.tag.pixel;
      upd_in.n     = p_ff.tag.n;
      upd_in.mean  = p_ff.mean;
      upd_in.sum   = new_sum;
      upd_in.sat   = new_sat;
   end

   // Hold a reading item with a non-zero frame while an older one for the same pixel has not been written back.
   always_comb begin
      match = (a_tag_ff.valid && a_tag_ff.pixel == in_pixel) ||
              (m_ff.tag.valid && m_ff.tag.pixel == in_pixel) ||
              (p_ff.tag.valid && p_ff.tag.pixel == in_pixel);
      for (int i = 0; i < NS; i++) begin
         match = match || (dv_ff[i].tag.valid && dv_ff[i].tag.pixel == in_pixel);
      end
      hazard = (in_frame != '0) && match;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff.valid <= 1'b0;
         for (int i = 0; i < NS; i++) begin
            dv_ff[i].tag.valid <= 1'b0;
         end
         m_ff.tag.valid <= 1'b0;
         p_ff.tag.valid <= 1'b0;
         upd_ff.valid   <= 1'b0;
      end else if (adv) begin
         a_tag_ff  <= a_tag_in;
         a_prod_ff <= a_prod_in;
         for (int i = 0; i < NS; i++) begin
            dv_ff[i] <= dv_in[i];
         end
         m_ff   <= m_in;
         p_ff   <= p_in;
         upd_ff <= upd_in;
      end
   end

   assign upd = upd_ff;

   `DFMS_ASSERT_NEVER(a_no_stale_read, clock, reset, wr_en && a_tag_ff.valid && !a_tag_ff.first && p_ff.tag.pixel == a_tag_ff.pixel)

endmodule

/* hw/rtl/dfms_result.sv */
module dfms_result (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  dfms_pkg::upd_type  upd,
   output logic               res_valid,
   output dfms_pkg::rsp_type  res
);

   localparam int SW = dfms_pkg::SUM_W;
   localparam int RW = dfms_pkg::ROOT_W;
   localparam int QW = dfms_pkg::SQ_REM_W;
   localparam int NR = dfms_pkg::RES_STAGES;
   localparam int NQ = dfms_pkg::SQRT_STAGES;

   typedef struct packed {
      logic                          valid;
      logic [dfms_pkg::PIX_W-1:0]    pixel;
      logic [dfms_pkg::VAL_W-1:0]    mean;
      logic                          sat;
      logic [dfms_pkg::N_W-1:0]      n;
      logic [SW-1:0]                 dvd;
      logic [dfms_pkg::N_W-1:0]      rem;
      logic [SW-1:0]                 quo;
   } rs_type;

   typedef struct packed {
      logic                          valid;
      logic [dfms_pkg::PIX_W-1:0]    pixel;
      logic [dfms_pkg::VAL_W-1:0]    mean;
      logic                          sat;
      logic [SW-1:0]                 v;
      logic [QW-1:0]                 rem;
      logic [RW-1:0]                 root;
   } sq_type;

   function automatic rs_type rs_step2(input rs_type x);
      rs_type                  y;
      logic [dfms_pkg::N_W:0]  r;
      y = x;
      for (int j = 0; j < 2; j++) begin
         r     = dfms_pkg::div_bit(y.rem, y.dvd[SW-1], y.n);
         y.rem = r[dfms_pkg::N_W-1:0];
         y.quo = {y.quo[SW-2:0], r[dfms_pkg::N_W]};
         y.dvd = {y.dvd[SW-2:0], 1'b0};
      end
      return y;
   endfunction

   // One root bit per stage: bring down two radicand bits, try 4*root+1.
   function automatic sq_type sq_step(input sq_type x);
      sq_type        y;
      logic [QW-1:0] rt;
      logic [QW-1:0] trial;
      y     = x;
      rt    = {x.rem[QW-3:0], x.v[SW-1:SW-2]};
      trial = {x.root[QW-3:0], 2'b01};
      if (rt >= trial) begin
         y.rem  = rt - trial;
         y.root = {x.root[RW-2:0], 1'b1};
      end else begin
         y.rem  = rt;
         y.root = {x.root[RW-2:0], 1'b0};
      end
      y.v = {x.v[SW-3:0], 2'b00};
      return y;
   endfunction

   rs_type rs_ff [NR];
   rs_type rs_in [NR];
   rs_type rs_first;
   sq_type sq_ff [NQ];
   sq_type sq_in [NQ];
   sq_type sq_first;

   always_comb begin
      rs_first.valid = upd.valid;
      rs_first.pixel = upd.pixel;
      rs_first.mean  = upd.mean;
      rs_first.sat   = upd.sat;
      rs_first.n     = upd.n;
      rs_first.dvd   = upd.sum;
      rs_first.rem   = '0;
      rs_first.quo   = '0;
      rs_in[0] = rs_step2(rs_first);
      for (int i = 1; i < NR; i++) begin
         rs_in[i] = rs_step2(rs_ff[i-1]);
      end
      sq_first.valid = rs_ff[NR-1].valid;
      sq_first.pixel = rs_ff[NR-1].pixel;
      sq_first.mean  = rs_ff[NR-1].mean;
      sq_first.sat   = rs_ff[NR-1].sat;
      sq_first.v     = rs_ff[NR-1].quo;
      sq_first.rem   = '0;
      sq_first.root  = '0;
      sq_in[0] = sq_step(sq_first);
      for (int i = 1; i < NQ; i++) begin
         sq_in[i] = sq_step(sq_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NR; i++) begin
            rs_ff[i].valid <= 1'b0;
         end
         for (int i = 0; i < NQ; i++) begin
            sq_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         for (int i = 0; i < NR; i++) begin
            rs_ff[i] <= rs_in[i];
         end
         for (int i = 0; i < NQ; i++) begin
            sq_ff[i] <= sq_in[i];
         end
      end
   end

   always_comb begin
      res_valid = sq_ff[NQ-1].valid;
      res.pixel = sq_ff[NQ-1].pixel;
      res.mean  = sq_ff[NQ-1].mean;
      res.sat   = sq_ff[NQ-1].sat;
      if (sq_ff[NQ-1].root > RW'(dfms_pkg::VAL_MAX)) begin
         res.std = dfms_pkg::VAL_MAX;
      end else begin
         res.std = sq_ff[NQ-1].root[dfms_pkg::VAL_W-1:0];
      end
   end

endmodule

/* hw/rtl/dark_frame_mean_std.sv */
// Per-pixel dark-frame statistics. Each transfer on req_ carries one raw sample, its
// flat-field gain (Q2.14), its pixel and frame index; the gain-scaled value (Q18.8) updates
// that pixel's running Welford mean and squared-deviation sum, held in one 65536-entry
// on-chip memory (read, modify, write back). Frame 0 initializes a pixel; a transfer
// flagged final_frame yields one rsp_ transfer with the pixel's mean, population standard
// deviation and sticky saturation flag. The block takes one item per cycle unless stalled.
// A non-zero frame for a pixel that is still in the 16-deep update pipeline (signed divide
// by the frame count, multiply, accumulate) is held until that write-back lands, so repeats
// of one pixel within 16 items of each other stall the input. A result passes through 17
// update stages, 32 stages of the 64-bit divide, 32 stages of the square root and the
// output buffer before it can leave as an rsp_ transfer. A two-entry output buffer keeps the
// pipeline running while a result waits; the pipeline holds only while that buffer is full.
`include "dark_frame_mean_std_macros.svh"

module dark_frame_mean_std (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [dfms_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic [dfms_pkg::GAIN_W-1:0]    req_flat_gain,
   input  logic [dfms_pkg::PIX_W-1:0]     req_pixel_index,
   input  logic [dfms_pkg::FRAME_W-1:0]   req_frame_index,
   input  logic                           req_final_frame,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [dfms_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic [dfms_pkg::VAL_W-1:0]     rsp_mean_value,
   output logic [dfms_pkg::VAL_W-1:0]     rsp_std_value,
   output logic                           rsp_saturated
);

   logic               adv;
   logic               hazard;
   logic               accept;
   logic               push;
   logic               pop;
   dfms_pkg::upd_type  upd;
   logic               res_valid;
   dfms_pkg::rsp_type  res;

   dfms_pkg::rsp_type  fifo_ff [2];
   logic               wptr_ff, wptr_in;
   logic               rptr_ff, rptr_in;
   logic [1:0]         cnt_ff, cnt_in;

   // Advance the whole pipeline unless the output buffer is full.
   assign adv       = (cnt_ff != dfms_pkg::FIFO_FULL);
   assign req_stall = !adv || hazard;
   assign accept    = req_valid && !req_stall;
   assign push      = adv && res_valid;
   assign pop       = rsp_valid && !rsp_stall;

   dfms_update u_update (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_accept (accept),
      .in_sample (req_sample),
      .in_gain   (req_flat_gain),
      .in_pixel  (req_pixel_index),
      .in_frame  (req_frame_index),
      .in_last   (req_final_frame),
      .hazard    (hazard),
      .upd       (upd)
   );

   dfms_result u_result (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .upd       (upd),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wptr_ff] <= res;
      end
   end

   assign rsp_valid      = (cnt_ff != 2'd0);
   assign rsp_pixel_out  = fifo_ff[rptr_ff].pixel;
   assign rsp_mean_value = fifo_ff[rptr_ff].mean;
   assign rsp_std_value  = fifo_ff[rptr_ff].std;
   assign rsp_saturated  = fifo_ff[rptr_ff].sat;

   `DFMS_ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff > dfms_pkg::FIFO_FULL)
   `DFMS_ASSERT_NEVER(a_no_overflow, clock, reset, push && !pop && cnt_ff == dfms_pkg::FIFO_FULL)
   `DFMS_ASSERT_IMPLIES(a_stall_cause, clock, reset, req_stall && !hazard, cnt_ff == dfms_pkg::FIFO_FULL)

endmodule

/* dv/dark_frame_mean_std_test.sv */
`timescale 1ns / 1ps

module dark_frame_mean_std_test;

   localparam int IDLE_LIMIT = 5000;
   localparam int SAT_PAIRS  = 100;
   localparam int RAND_ITEMS = 1180;

   typedef struct {
      logic [dfms_pkg::SAMPLE_W-1:0] sample;
      logic [dfms_pkg::GAIN_W-1:0]   gain;
      logic [dfms_pkg::PIX_W-1:0]    pixel;
      logic [dfms_pkg::FRAME_W-1:0]  frame;
      logic                          last;
      bit                            typed;
      dfms_pkg::rsp_type             known;
   } dark_item;

   typedef struct {
      bit                typed;
      dfms_pkg::rsp_type known;
   } typed_note;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [dfms_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic [dfms_pkg::GAIN_W-1:0]   req_flat_gain = '0;
   logic [dfms_pkg::PIX_W-1:0]    req_pixel_index = '0;
   logic [dfms_pkg::FRAME_W-1:0]  req_frame_index = '0;
   logic                          req_final_frame = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [dfms_pkg::PIX_W-1:0] rsp_pixel_out;
   logic [dfms_pkg::VAL_W-1:0] rsp_mean_value;
   logic [dfms_pkg::VAL_W-1:0] rsp_std_value;
   logic                       rsp_saturated;

   dark_frame_mean_std dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state, one entry per pixel
   logic [dfms_pkg::VAL_W-1:0] mean_mem [65536];
   logic [dfms_pkg::SUM_W-1:0] sum_mem [65536];
   bit                         sat_mem [65536];

   dfms_pkg::rsp_type stats_q[$];
   typed_note         note_q[$];
   int        errors = 0;
   int        req_count = 0;
   int        rsp_count = 0;
   int        sent = 0;
   int        idle = 0;
   bit        seen_pix [65536];

   function automatic logic [63:0] floor_root(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   function automatic void fold_sample(input logic [15:0] s, input logic [15:0] g,
                                       input logic [15:0] k, input logic [9:0] f,
                                       input logic fin, output bit emits,
                                       output dfms_pkg::rsp_type r);
      logic [31:0] scaled;
      longint signed pix, old, mnew, d, n, sq;
      logic [63:0] inc, nu, var_q, root;
      scaled = {16'b0, s} * {16'b0, g};
      pix = longint'({38'b0, scaled[31:6]});
      n = longint'(f) + 1;
      if (f == 0) begin
         mean_mem[k] = pix[25:0];
         sum_mem[k] = '0;
         sat_mem[k] = 1'b0;
      end else begin
         old = longint'({38'b0, mean_mem[k]});
         d = pix - old;
         mnew = old + d / n;
         mean_mem[k] = mnew[25:0];
         sq = d * (pix - mnew);
         if (sq > 0) begin
            inc = sq;
            if (sum_mem[k] > ~64'd0 - inc) begin
               sum_mem[k] = ~64'd0;
               sat_mem[k] = 1'b1;
            end else begin
               sum_mem[k] = sum_mem[k] + inc;
            end
         end
      end
      emits = fin;
      nu = n;
      var_q = sum_mem[k] / nu;
      root = floor_root(var_q);
      if (root > {38'b0, dfms_pkg::VAL_MAX}) root = {38'b0, dfms_pkg::VAL_MAX};
      r.pixel = k;
      r.mean = mean_mem[k];
      r.std = root[dfms_pkg::VAL_W-1:0];
      r.sat = sat_mem[k];
   endfunction

   task automatic report(input string fld, input logic [63:0] exp_v, input logic [63:0] act_v);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, exp_v, act_v);
      errors++;
   endtask

   // Input side: predict on every transfer
   always @(posedge clock) begin
      bit emits;
      dfms_pkg::rsp_type r;
      typed_note tn;
      if (!reset && req_valid && !req_stall) begin
         fold_sample(req_sample, req_flat_gain, req_pixel_index, req_frame_index,
                     req_final_frame, emits, r);
         tn = note_q.pop_front();
         if (emits) stats_q.push_back(tn.typed ? tn.known : r);
         req_count <= req_count + 1;
      end
   end

   // Output side: compare against the oldest expectation
   always @(posedge clock) begin
      dfms_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stats_q.size() == 0) begin
            $display("%0t: unexpected result for pixel %0h", $time, rsp_pixel_out);
            errors++;
         end else begin
            e = stats_q.pop_front();
            if (rsp_pixel_out !== e.pixel) report("pixel_out", e.pixel, rsp_pixel_out);
            if (rsp_mean_value !== e.mean) report("mean_value", e.mean, rsp_mean_value);
            if (rsp_std_value !== e.std) report("std_value", e.std, rsp_std_value);
            if (rsp_saturated !== e.sat) report("saturated", e.sat, rsp_saturated);
         end
         rsp_count <= rsp_count + 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle <= 0;
      end else if (idle >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle <= idle + 1;
      end
   end

   // Receiver: random stall runs, plus one long hold-off to back up the pipeline
   initial begin
      bit held;
      bit v;
      int len;
      held = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && sent >= 40) begin
            held = 1;
            len = 600;
            v = 1'b1;
         end else begin
            v = ($urandom_range(0, 2) == 0);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
         end
         repeat (len) begin
            rsp_stall <= v;
            @(negedge clock);
         end
      end
   end

   task automatic send(input dark_item it, input bit no_gaps);
      int gap;
      int prev;
      typed_note tn;
      gap = 0;
      if (!no_gaps) begin
         case ($urandom_range(0, 15))
            0:       gap = $urandom_range(10, 40);
            1, 2, 3,
            4, 5, 6: gap = $urandom_range(1, 3);
            default: gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      tn.typed = it.typed;
      tn.known = it.known;
      note_q.push_back(tn);
      prev = req_count;
      req_valid <= 1'b1;
      req_sample <= it.sample;
      req_flat_gain <= it.gain;
      req_pixel_index <= it.pixel;
      req_frame_index <= it.frame;
      req_final_frame <= it.last;
      seen_pix[it.pixel] = 1'b1;
      sent++;
      do @(negedge clock); while (req_count == prev);
   endtask

   function automatic logic [15:0] rand16();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic dark_item mk(input logic [15:0] s, input logic [15:0] g,
                                   input logic [15:0] k, input logic [9:0] f,
                                   input logic fin);
      dark_item it;
      it.sample = s;
      it.gain = g;
      it.pixel = k;
      it.frame = f;
      it.last = fin;
      it.typed = 0;
      it.known = '0;
      return it;
   endfunction

   dark_item table_rows[$];
   logic [15:0] pool [16];

   initial begin
      dark_item it;
      logic [15:0] sat_pix;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows
      it = mk(16'h0000, 16'h0000, 16'h0000, 10'd0, 1'b1);
      it.typed = 1;
      it.known = '{pixel: 16'h0000, mean: 26'h0, std: 26'h0, sat: 1'b0};
      table_rows.push_back(it);
      it = mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd0, 1'b1);
      it.typed = 1;
      it.known = '{pixel: 16'hFFFF, mean: 26'h3FFF800, std: 26'h0, sat: 1'b0};
      table_rows.push_back(it);
      table_rows.push_back(mk(16'd100, 16'h4000, 16'd5, 10'd0, 1'b0));
      table_rows.push_back(mk(16'd300, 16'h4000, 16'd5, 10'd1, 1'b1));
      table_rows.push_back(mk(16'hFFFF, 16'hFFFF, 16'd5, 10'd1023, 1'b1));
      table_rows.push_back(mk(16'd1000, 16'h4000, 16'd7, 10'd0, 1'b0));
      table_rows.push_back(mk(16'd10, 16'h4000, 16'd7, 10'd3, 1'b1));
      table_rows.push_back(mk(16'd500, 16'h2000, 16'd9, 10'd0, 1'b0));
      table_rows.push_back(mk(16'd100, 16'h2000, 16'd9, 10'd1, 1'b0));
      table_rows.push_back(mk(16'd0, 16'h2000, 16'd9, 10'd2, 1'b1));
      for (int f = 0; f < 6; f++)
         table_rows.push_back(mk(16'(f * 7919), 16'hC000, 16'd12, 10'(f), f == 5));
      table_rows.push_back(mk(16'hFFFF, 16'h0001, 16'h8000, 10'd0, 1'b0));
      table_rows.push_back(mk(16'h0001, 16'hFFFF, 16'h8000, 10'd512, 1'b1));
      foreach (table_rows[i]) send(table_rows[i], 1'b0);

      // Random items on a small set of busy pixels plus scattered ones
      foreach (pool[i]) pool[i] = 16'($urandom_range(0, 65535));
      for (int i = 0; i < RAND_ITEMS; i++) begin
         it = mk(rand16(), rand16(), 16'h0, 10'd0, $urandom_range(0, 4) == 0);
         it.pixel = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                : pool[$urandom_range(0, 15)];
         if (seen_pix[it.pixel]) begin
            case ($urandom_range(0, 9))
               0:       it.frame = 10'd0;
               1, 2:    it.frame = 10'($urandom_range(0, 1023));
               default: it.frame = 10'($urandom_range(1, 15));
            endcase
         end
         send(it, i >= 600 && i < 700);
      end

      // Grow one pixel's sum fast: alternate a full-scale sample at a large
      // frame count with a zero sample that pulls the mean down
      sat_pix = 16'hA5A5;
      send(mk(16'h0, 16'h0, sat_pix, 10'd0, 1'b0), 1'b1);
      for (int i = 0; i < SAT_PAIRS; i++) begin
         send(mk(16'hFFFF, 16'hFFFF, sat_pix, 10'd1023, 1'b0), 1'b1);
         send(mk(16'h0, rand16(), sat_pix, 10'd1, 1'b0), 1'b1);
      end
      send(mk(16'hFFFF, 16'hFFFF, sat_pix, 10'd1023, 1'b1), 1'b0);
      req_valid <= 1'b0;

      while (stats_q.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (errors == 0 && stats_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/dfms_pkg.sv
hw/rtl/dfms_ram.sv
hw/rtl/dfms_update.sv
hw/rtl/dfms_result.sv
hw/rtl/dark_frame_mean_std.sv
dv/dark_frame_mean_std_test.sv
